>>> rtl/mtq_pkg.sv
package mtq_pkg;

  localparam logic [3:0] REQ_ENQ          = 4'd0;
  localparam logic [3:0] REQ_PUSH_FRONT   = 4'd1;
  localparam logic [3:0] REQ_DEQ          = 4'd2;
  localparam logic [3:0] REQ_DEQ_ADDR     = 4'd3;
  localparam logic [3:0] REQ_DEQ_TID_ADDR = 4'd4;
  localparam logic [3:0] REQ_PEEK         = 4'd5;
  localparam logic [3:0] REQ_PEEK_TID     = 4'd6;
  localparam logic [3:0] REQ_REMOVE_HEAD  = 4'd7;
  localparam logic [3:0] REQ_REMOVE_ID    = 4'd8;
  localparam logic [3:0] REQ_CNT_ADDR     = 4'd9;
  localparam logic [3:0] REQ_CNT_TID_ADDR = 4'd10;
  localparam logic [3:0] REQ_IS_EMPTY     = 4'd11;
  localparam logic [3:0] REQ_TOTALS       = 4'd12;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_POLICY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKETS = 2'd2;

  localparam logic [31:0] MAX_DELAY_RST   = 32'd500000;
  localparam logic [6:0]  MAX_PACKETS_RST = 7'd64;

  localparam logic [1:0]  KIND_NQOS = 2'd1;
  localparam logic [1:0]  KIND_QOS  = 2'd2;
  localparam logic [6:0]  COUNT_SAT = 7'd127;
  localparam logic [21:0] BYTES_SAT = 22'h3FFFFF;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] now;
    logic [15:0] packet_id;
    logic [47:0] dest_addr;
    logic [1:0]  frame_kind;
    logic [3:0]  tid;
    logic [15:0] byte_size;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_packet_id;
    logic [47:0] out_dest_addr;
    logic [1:0]  out_frame_kind;
    logic [3:0]  out_tid;
    logic [15:0] out_byte_size;
    logic [31:0] out_stamp;
    logic [6:0]  match_count;
    logic [21:0] byte_total;
  } rsp_t;

  typedef struct packed {
    logic [47:0] addr;
    logic [15:0] id;
    logic [1:0]  kind;
    logic [3:0]  tid;
    logic [15:0] size;
    logic [31:0] stamp;
  } frame_t;

  typedef enum logic [1:0] {MM_ALL, MM_ADDR, MM_TID, MM_ID} mm_e;
  typedef enum logic [1:0] {MK_NONE, MK_SCAN, MK_ALL, MK_FIRST_STALE} mark_e;
  typedef enum logic [2:0] {
    COP_HOLD, COP_EVAL, COP_MARK, COP_COLLAPSE, COP_HEAD_DEAD, COP_TAIL, COP_PUSH
  } cop_e;

  typedef struct packed {
    cop_e        op;
    mm_e         mm;
    mark_e       mk;
    logic        kill;
    logic [31:0] now;
    logic [31:0] max_delay;
    frame_t      nf;
  } ctl_t;

  // Prefix flags rippled from the head toward the tail.
  typedef struct packed {
    logic cand;
    logic stale;
    logic hole;
  } chain_t;

endpackage

>>> rtl/mtq_if.sv
interface mtq_req_if;
  import mtq_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mtq_rsp_if;
  import mtq_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mtq_cfg_if;
  import mtq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/mtq_cell.sv
module mtq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mtq_pkg::ctl_t   ctl_i,
  input  logic            occ_i,
  input  logic            tail_i,
  input  logic            first_i,
  input  mtq_pkg::frame_t left_i,
  input  mtq_pkg::frame_t right_i,
  input  logic            right_dead_i,
  input  mtq_pkg::chain_t chain_i,
  output mtq_pkg::chain_t chain_o,
  output mtq_pkg::frame_t frame_o,
  output logic            dead_o,
  output mtq_pkg::frame_t hit_o,
  output logic            cnt_o,
  output logic [15:0]     rm_size_o
);
  import mtq_pkg::*;

  frame_t frame_q, frame_d;
  logic   dead_q, dead_d, stale_q, stale_d, match_q, match_d;
  logic   cand, first_cand, stale_now, match_now, addr_eq;

  assign cand       = occ_i & ~stale_q & match_q;
  assign first_cand = cand & ~chain_i.cand;

  assign chain_o.cand  = chain_i.cand | cand;
  assign chain_o.stale = chain_i.stale | (occ_i & stale_q);
  assign chain_o.hole  = chain_i.hole | dead_q;

  assign frame_o   = frame_q;
  assign dead_o    = dead_q;
  assign hit_o     = first_cand ? frame_q : '0;
  assign cnt_o     = cand;
  assign rm_size_o = (dead_q & ~chain_i.hole) ? frame_q.size : 16'd0;

  // Expiry bound is formed on 33 bits so it never wraps.
  assign stale_now = {1'b0, ctl_i.now} > ({1'b0, frame_q.stamp} + {1'b0, ctl_i.max_delay});
  assign addr_eq   = (frame_q.addr == ctl_i.nf.addr);

  always_comb begin
    case (ctl_i.mm)
      MM_ALL:  match_now = 1'b1;
      MM_ADDR: match_now = addr_eq & ((frame_q.kind == KIND_NQOS) | (frame_q.kind == KIND_QOS));
      MM_TID:  match_now = addr_eq & (frame_q.kind == KIND_QOS) & (frame_q.tid == ctl_i.nf.tid);
      MM_ID:   match_now = (frame_q.id == ctl_i.nf.id);
      default: match_now = 1'b0;
    endcase
  end

  always_comb begin
    frame_d = frame_q;
    dead_d  = dead_q;
    stale_d = stale_q;
    match_d = match_q;
    case (ctl_i.op)
      COP_EVAL: begin
        stale_d = stale_now;
        match_d = match_now;
      end
      COP_MARK: begin
        case (ctl_i.mk)
          MK_SCAN:        dead_d = (occ_i & stale_q & ~chain_i.cand) | (first_cand & ctl_i.kill);
          MK_ALL:         dead_d = occ_i & stale_q;
          MK_FIRST_STALE: dead_d = occ_i & stale_q & ~chain_i.stale;
          default:        dead_d = 1'b0;
        endcase
      end
      COP_COLLAPSE: begin
        // Everything from the first hole onward moves one place toward the head.
        if (chain_i.hole | dead_q) begin
          frame_d = right_i;
          dead_d  = right_dead_i;
        end
      end
      COP_HEAD_DEAD: dead_d = first_i;
      COP_TAIL: begin
        if (tail_i) begin
          frame_d = ctl_i.nf;
        end
      end
      COP_PUSH: frame_d = left_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_q  <= 1'b0;
      stale_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      dead_q  <= dead_d;
      stale_q <= stale_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

endmodule

>>> rtl/mac_tx_queue_with_aging.sv
// Each request runs alone: evaluate, mark, close the gaps left by removed frames one at
// a time, then a head drop, an insert or a match count, then respond.
// Requests are taken only while idle, so each one is finished before the next is taken;
// a finished response may wait while the next request runs.
// Reset empties the queue and loads register defaults; slots are not cleared.
module mac_tx_queue_with_aging #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtq_req_if.sink    req_i,
  mtq_rsp_if.source  rsp_o,
  mtq_cfg_if.sink    cfg_i
);
  import mtq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int BW    = $clog2(QUEUE_DEPTH * 65535 + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_MARK, S_COLLAPSE, S_HEAD, S_INSERT, S_COUNT, S_RESP
  } state_e;

  state_e           state_q;
  req_t             req_q;
  logic [CNT_W-1:0] fill_q;
  logic [BW-1:0]    bytes_q;
  logic [31:0]      mdelay_q;
  logic             pol_q;
  logic [6:0]       maxp_q;
  logic             found_q, head_done_q, ins_ok_q;
  frame_t           hit_q;
  logic [QUEUE_DEPTH-1:0] cntv_q;
  logic [6:0]       count_q;
  logic             rsp_valid_q;
  rsp_t             rsp_q, rsp_d;

  ctl_t   ctl;
  chain_t chain [QUEUE_DEPTH+1];
  frame_t frames [QUEUE_DEPTH];
  frame_t hits [QUEUE_DEPTH];
  logic [15:0] rm_sizes [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] deads, occ, cntv;
  frame_t hit_any;
  logic [15:0] rm_size;
  logic   any_dead, full, is_ins, is_scan, is_all, drop_head;
  logic [31:0] cap32, mp32;

  assign chain[0] = '0;
  assign any_dead = chain[QUEUE_DEPTH].hole;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    assign occ[g] = CNT_W'(g) < fill_q;
    mtq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .occ_i        (occ[g]),
      .tail_i       (CNT_W'(g) == fill_q),
      .first_i      (g == 0),
      .left_i       ((g == 0) ? ctl.nf : frames[(g == 0) ? 0 : g-1]),
      .right_i      ((g == QUEUE_DEPTH-1) ? '0 : frames[(g == QUEUE_DEPTH-1) ? g : g+1]),
      .right_dead_i ((g == QUEUE_DEPTH-1) ? 1'b0 : deads[(g == QUEUE_DEPTH-1) ? g : g+1]),
      .chain_i      (chain[g]),
      .chain_o      (chain[g+1]),
      .frame_o      (frames[g]),
      .dead_o       (deads[g]),
      .hit_o        (hits[g]),
      .cnt_o        (cntv[g]),
      .rm_size_o    (rm_sizes[g])
    );
  end

  always_comb begin
    hit_any = '0;
    rm_size = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit_any = hit_any | hits[i];
      rm_size = rm_size | rm_sizes[i];
    end
  end

  always_comb begin
    mp32  = {25'd0, maxp_q};
    cap32 = (mp32 == 32'd0) ? 32'd1 :
            (mp32 > 32'(QUEUE_DEPTH)) ? 32'(QUEUE_DEPTH) : mp32;
    full  = 32'(fill_q) >= cap32;
  end

  assign is_ins  = (req_q.req_type == REQ_ENQ) || (req_q.req_type == REQ_PUSH_FRONT);
  assign is_scan = (req_q.req_type == REQ_DEQ) || (req_q.req_type == REQ_DEQ_ADDR) ||
                   (req_q.req_type == REQ_DEQ_TID_ADDR) || (req_q.req_type == REQ_PEEK_TID) ||
                   (req_q.req_type == REQ_REMOVE_HEAD) || (req_q.req_type == REQ_REMOVE_ID) ||
                   (req_q.req_type == REQ_IS_EMPTY);
  assign is_all  = (req_q.req_type == REQ_CNT_ADDR) || (req_q.req_type == REQ_CNT_TID_ADDR) ||
                   (req_q.req_type == REQ_TOTALS);
  assign drop_head = is_ins && full && pol_q && !head_done_q;

  always_comb begin
    ctl.now       = req_q.now;
    ctl.max_delay = mdelay_q;
    ctl.nf        = '{addr: req_q.dest_addr, id: req_q.packet_id, kind: req_q.frame_kind,
                      tid: req_q.tid, size: req_q.byte_size, stamp: req_q.now};
    ctl.kill = (req_q.req_type == REQ_DEQ) || (req_q.req_type == REQ_DEQ_ADDR) ||
               (req_q.req_type == REQ_DEQ_TID_ADDR) || (req_q.req_type == REQ_REMOVE_HEAD) ||
               (req_q.req_type == REQ_REMOVE_ID);
    case (req_q.req_type)
      REQ_DEQ_ADDR, REQ_CNT_ADDR:                       ctl.mm = MM_ADDR;
      REQ_DEQ_TID_ADDR, REQ_PEEK_TID, REQ_CNT_TID_ADDR: ctl.mm = MM_TID;
      REQ_REMOVE_ID:                                    ctl.mm = MM_ID;
      default:                                          ctl.mm = MM_ALL;
    endcase
    if (is_ins) begin
      ctl.mk = full ? MK_FIRST_STALE : MK_NONE;
    end else if (is_scan) begin
      ctl.mk = MK_SCAN;
    end else if (is_all) begin
      ctl.mk = MK_ALL;
    end else begin
      ctl.mk = MK_NONE;
    end
    case (state_q)
      S_EVAL:     ctl.op = COP_EVAL;
      S_MARK:     ctl.op = COP_MARK;
      S_COLLAPSE: ctl.op = any_dead ? COP_COLLAPSE : COP_HOLD;
      S_HEAD:     ctl.op = drop_head ? COP_HEAD_DEAD : COP_HOLD;
      S_INSERT: begin
        if (full) begin
          ctl.op = COP_HOLD;
        end else if (req_q.req_type == REQ_ENQ) begin
          ctl.op = COP_TAIL;
        end else begin
          ctl.op = COP_PUSH;
        end
      end
      default:    ctl.op = COP_HOLD;
    endcase
  end

  always_comb begin
    rsp_d        = '0;
    rsp_d.status = ST_MISS;
    case (req_q.req_type)
      REQ_ENQ, REQ_PUSH_FRONT: rsp_d.status = ins_ok_q ? ST_OK : ST_FULL;
      REQ_DEQ, REQ_DEQ_ADDR, REQ_DEQ_TID_ADDR, REQ_PEEK, REQ_PEEK_TID,
      REQ_REMOVE_HEAD: begin
        rsp_d.status = found_q ? ST_OK : ST_MISS;
        if (found_q) begin
          rsp_d.out_packet_id  = hit_q.id;
          rsp_d.out_dest_addr  = hit_q.addr;
          rsp_d.out_frame_kind = hit_q.kind;
          rsp_d.out_tid        = hit_q.tid;
          rsp_d.out_byte_size  = hit_q.size;
          rsp_d.out_stamp      = hit_q.stamp;
        end
      end
      REQ_REMOVE_ID: rsp_d.status = found_q ? ST_OK : ST_MISS;
      REQ_IS_EMPTY:  rsp_d.status = found_q ? ST_MISS : ST_OK;
      REQ_CNT_ADDR, REQ_CNT_TID_ADDR: begin
        rsp_d.status      = ST_OK;
        rsp_d.match_count = count_q;
      end
      REQ_TOTALS: begin
        rsp_d.status      = ST_OK;
        rsp_d.match_count = (32'(fill_q) > 32'(COUNT_SAT)) ? COUNT_SAT : 7'(fill_q);
        rsp_d.byte_total  = (32'(bytes_q) > 32'(BYTES_SAT)) ? BYTES_SAT : 22'(bytes_q);
      end
      default: ;
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      bytes_q     <= '0;
      mdelay_q    <= MAX_DELAY_RST;
      pol_q       <= 1'b0;
      maxp_q      <= MAX_PACKETS_RST;
      found_q     <= 1'b0;
      head_done_q <= 1'b0;
      ins_ok_q    <= 1'b0;
      cntv_q      <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_MAX_DELAY:   mdelay_q <= cfg_i.wdata;
          REG_DROP_POLICY: pol_q    <= cfg_i.wdata[0];
          REG_MAX_PACKETS: maxp_q   <= cfg_i.wdata[6:0];
          default: ;
        endcase
      end
      if (state_q == S_RESP && (!rsp_valid_q || rsp_o.ready)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            state_q     <= S_EVAL;
            head_done_q <= 1'b0;
            ins_ok_q    <= 1'b0;
            count_q     <= '0;
          end
        end
        S_EVAL: state_q <= S_MARK;
        S_MARK: begin
          found_q <= chain[QUEUE_DEPTH].cand;
          hit_q   <= hit_any;
          cntv_q  <= cntv;
          state_q <= S_COLLAPSE;
        end
        S_COLLAPSE: begin
          if (any_dead) begin
            fill_q  <= fill_q - CNT_W'(1);
            bytes_q <= bytes_q - BW'(rm_size);
          end else if (is_ins) begin
            state_q <= S_HEAD;
          end else if ((req_q.req_type == REQ_CNT_ADDR) ||
                       (req_q.req_type == REQ_CNT_TID_ADDR)) begin
            state_q <= S_COUNT;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_HEAD: begin
          if (drop_head) begin
            head_done_q <= 1'b1;
            state_q     <= S_COLLAPSE;
          end else begin
            state_q <= S_INSERT;
          end
        end
        S_INSERT: begin
          if (!full) begin
            fill_q   <= fill_q + CNT_W'(1);
            bytes_q  <= bytes_q + BW'(req_q.byte_size);
            ins_ok_q <= 1'b1;
          end
          state_q <= S_RESP;
        end
        S_COUNT: begin
          // Peel off the lowest matching cell each cycle.
          if (cntv_q != '0) begin
            cntv_q <= cntv_q & (cntv_q - QUEUE_DEPTH'(1));
            if (count_q != COUNT_SAT) begin
              count_q <= count_q + 7'd1;
            end
          end else begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.valid) begin
      req_q <= req_i.data;
    end
    if (state_q == S_RESP && (!rsp_valid_q || rsp_o.ready)) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

>>> rtl/mtq_checker.sv
module mtq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input mtq_pkg::rsp_t rsp_data_i
);
  import mtq_pkg::*;

  // A response that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_data_i.status == ST_OK) || (rsp_data_i.status == ST_MISS) ||
                    (rsp_data_i.status == ST_FULL))
    else $error("undefined status code");

  // Failed requests carry no frame, count or byte total.
  a_miss_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.status != ST_OK) |->
      (rsp_data_i.out_packet_id == 16'd0) && (rsp_data_i.out_stamp == 32'd0) &&
      (rsp_data_i.match_count == 7'd0) && (rsp_data_i.byte_total == 22'd0))
    else $error("payload on a failed request");

  // Only one request is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

endmodule

bind mac_tx_queue_with_aging mtq_checker u_mtq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

>>> tb/mac_tx_queue_with_aging_tb.sv
module mac_tx_queue_with_aging_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtq_pkg::*;

  localparam int DEPTH = 64;

  typedef struct {
    req_t r;
    bit   known;
    rsp_t e;
  } row_t;

  logic clk_i;
  logic rst_ni;

  mtq_req_if rq ();
  mtq_rsp_if rs ();
  mtq_cfg_if cf ();

  mac_tx_queue_with_aging #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rq),
    .rsp_o  (rs),
    .cfg_i  (cf)
  );

  // Shadow of the queue and its registers.
  frame_t      shadow_q[$];
  logic [22:0] shadow_bytes;
  logic [31:0] life_ticks;
  logic        head_drop;
  logic [6:0]  cap_reg;

  rsp_t        rsp_due[$];
  int unsigned mism_cnt;
  int unsigned fail_cnt;
  int unsigned n_req;
  int unsigned n_rsp;
  bit          idle_en;
  logic        hold_go;
  logic        hold_done;
  int unsigned hold_cnt;
  logic [31:0] tnow;
  logic [47:0] addr_pool[4];
  row_t        rows[$];

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #1_500_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic bit is_old(frame_t f, logic [31:0] now);
    return {1'b0, now} > ({1'b0, f.stamp} + {1'b0, life_ticks});
  endfunction

  function automatic void drop_slot(int i);
    shadow_bytes -= shadow_q[i].size;
    shadow_q.delete(i);
  endfunction

  function automatic bit frame_hit(frame_t f, mm_e mode, logic [47:0] addr, logic [3:0] tid);
    if (mode == MM_ALL) return 1'b1;
    if (f.addr != addr) return 1'b0;
    if (mode == MM_ADDR) return f.kind == KIND_NQOS || f.kind == KIND_QOS;
    return f.kind == KIND_QOS && f.tid == tid;
  endfunction

  // Walks from the head, removing stale frames it passes; returns the match
  // index or the queue size when nothing matched.
  function automatic int scan_head(logic [31:0] now, mm_e mode, logic [47:0] addr,
                                   logic [3:0] tid);
    int i;
    i = 0;
    while (i < shadow_q.size()) begin
      if (is_old(shadow_q[i], now)) drop_slot(i);
      else if (frame_hit(shadow_q[i], mode, addr, tid)) return i;
      else i++;
    end
    return i;
  endfunction

  function automatic void purge_stale(logic [31:0] now);
    int i;
    i = 0;
    while (i < shadow_q.size()) begin
      if (is_old(shadow_q[i], now)) drop_slot(i);
      else i++;
    end
  endfunction

  function automatic rsp_t frame_rsp(frame_t f);
    rsp_t o;
    o = '0;
    o.status = ST_OK;
    o.out_packet_id = f.id;
    o.out_dest_addr = f.addr;
    o.out_frame_kind = f.kind;
    o.out_tid = f.tid;
    o.out_byte_size = f.size;
    o.out_stamp = f.stamp;
    return o;
  endfunction

  function automatic rsp_t queue_step(req_t r);
    rsp_t   o;
    frame_t f;
    int     cap;
    int     i;
    int     n;
    mm_e    mode;
    o = '0;
    o.status = ST_MISS;
    cap = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    case (r.req_type)
      REQ_ENQ, REQ_PUSH_FRONT: begin
        if (shadow_q.size() >= cap) begin
          for (i = 0; i < shadow_q.size(); i++) begin
            if (is_old(shadow_q[i], r.now)) begin
              drop_slot(i);
              break;
            end
          end
        end
        if (shadow_q.size() >= cap && head_drop) drop_slot(0);
        if (shadow_q.size() >= cap) begin
          o.status = ST_FULL;
        end else begin
          f.addr = r.dest_addr;
          f.id = r.packet_id;
          f.kind = r.frame_kind;
          f.tid = r.tid;
          f.size = r.byte_size;
          f.stamp = r.now;
          if (r.req_type == REQ_ENQ) shadow_q.push_back(f);
          else shadow_q.push_front(f);
          shadow_bytes += r.byte_size;
          o.status = ST_OK;
        end
      end
      REQ_DEQ, REQ_DEQ_ADDR, REQ_DEQ_TID_ADDR, REQ_PEEK_TID, REQ_REMOVE_HEAD: begin
        mode = (r.req_type == REQ_DEQ_ADDR) ? MM_ADDR :
               (r.req_type == REQ_DEQ_TID_ADDR || r.req_type == REQ_PEEK_TID) ? MM_TID :
               MM_ALL;
        i = scan_head(r.now, mode, r.dest_addr, r.tid);
        if (i < shadow_q.size()) begin
          o = frame_rsp(shadow_q[i]);
          if (r.req_type != REQ_PEEK_TID) drop_slot(i);
        end
      end
      REQ_PEEK: begin
        foreach (shadow_q[j]) begin
          if (!is_old(shadow_q[j], r.now)) begin
            o = frame_rsp(shadow_q[j]);
            break;
          end
        end
      end
      REQ_REMOVE_ID: begin
        i = 0;
        while (i < shadow_q.size()) begin
          if (is_old(shadow_q[i], r.now)) begin
            drop_slot(i);
          end else if (shadow_q[i].id == r.packet_id) begin
            drop_slot(i);
            o.status = ST_OK;
            break;
          end else begin
            i++;
          end
        end
      end
      REQ_CNT_ADDR, REQ_CNT_TID_ADDR: begin
        purge_stale(r.now);
        mode = (r.req_type == REQ_CNT_ADDR) ? MM_ADDR : MM_TID;
        n = 0;
        foreach (shadow_q[j]) if (frame_hit(shadow_q[j], mode, r.dest_addr, r.tid)) n++;
        o.status = ST_OK;
        o.match_count = (n > 127) ? COUNT_SAT : 7'(n);
      end
      REQ_IS_EMPTY: begin
        i = scan_head(r.now, MM_ALL, '0, '0);
        o.status = (i < shadow_q.size()) ? ST_MISS : ST_OK;
      end
      REQ_TOTALS: begin
        purge_stale(r.now);
        o.status = ST_OK;
        o.match_count = (shadow_q.size() > 127) ? COUNT_SAT : 7'(shadow_q.size());
        o.byte_total = (shadow_bytes > 23'(BYTES_SAT)) ? BYTES_SAT : shadow_bytes[21:0];
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void check_fld(string nm, logic [63:0] e, logic [63:0] a);
    if (a !== e) begin
      mism_cnt++;
      if (mism_cnt <= 10)
        $display("mismatch on %s at response %0d: expected %0h, got %0h", nm, n_rsp, e, a);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rs.valid && rs.ready) begin
        if (rsp_due.size() == 0) begin
          fail_cnt++;
          $display("response with no request outstanding: %p", rs.data);
        end else begin
          rsp_t e;
          e = rsp_due.pop_front();
          check_fld("status", e.status, rs.data.status);
          check_fld("out_packet_id", e.out_packet_id, rs.data.out_packet_id);
          check_fld("out_dest_addr", e.out_dest_addr, rs.data.out_dest_addr);
          check_fld("out_frame_kind", e.out_frame_kind, rs.data.out_frame_kind);
          check_fld("out_tid", e.out_tid, rs.data.out_tid);
          check_fld("out_byte_size", e.out_byte_size, rs.data.out_byte_size);
          check_fld("out_stamp", e.out_stamp, rs.data.out_stamp);
          check_fld("match_count", e.match_count, rs.data.match_count);
          check_fld("byte_total", e.byte_total, rs.data.byte_total);
        end
        n_rsp++;
      end
      // A long hold-off lets requests pile up behind the one in flight.
      if (hold_go && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt  <= 400;
        rs.ready  <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        rs.ready <= 1'b0;
      end else begin
        rs.ready <= !(idle_en && $urandom_range(0, 99) < 26);
      end
    end else begin
      hold_done <= 1'b0;
      hold_cnt  <= 0;
      rs.ready  <= 1'b0;
    end
  end

  task automatic send_req(input req_t r, input bit known, input rsp_t e);
    rsp_t p;
    while (idle_en && $urandom_range(0, 99) < 26) begin
      rq.valid <= 1'b0;
      @(posedge clk_i);
    end
    rq.valid <= 1'b1;
    rq.data  <= r;
    @(posedge clk_i);
    while (!rq.ready) @(posedge clk_i);
    p = queue_step(r);
    rsp_due.push_back(known ? e : p);
    n_req++;
  endtask

  task automatic drain();
    rq.valid <= 1'b0;
    @(posedge clk_i);
    while (rsp_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [31:0] delay, input logic drop, input logic [6:0] cap);
    logic [31:0] v[3];
    v[0] = delay;
    v[1] = {31'b0, drop};
    v[2] = {25'b0, cap};
    for (int i = 0; i < 3; i++) begin
      cf.valid <= 1'b1;
      cf.index <= CFG_IDX_W'(i);
      cf.wdata <= v[i];
      @(posedge clk_i);
      while (!cf.ready) @(posedge clk_i);
    end
    cf.valid <= 1'b0;
    life_ticks  = delay;
    head_drop   = drop;
    cap_reg     = cap;
  endtask

  function automatic req_t mk_req(logic [3:0] op, logic [31:0] now, logic [15:0] id,
                                  logic [47:0] addr, logic [1:0] kind, logic [3:0] tid,
                                  logic [15:0] size);
    req_t r;
    r.req_type = op;
    r.now = now;
    r.packet_id = id;
    r.dest_addr = addr;
    r.frame_kind = kind;
    r.tid = tid;
    r.byte_size = size;
    return r;
  endfunction

  function automatic req_t rand_req(int enq_pct);
    int   w;
    req_t r;
    w = $urandom_range(0, 99);
    if (w < enq_pct) r.req_type = REQ_ENQ;
    else if (w < enq_pct + 10) r.req_type = REQ_PUSH_FRONT;
    else if (w < 97) r.req_type = 4'($urandom_range(REQ_DEQ, REQ_TOTALS));
    else r.req_type = 4'($urandom_range(13, 15));
    r.now = tnow;
    r.packet_id = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 7));
    r.dest_addr = ($urandom_range(0, 7) == 0) ? {16'($urandom()), 32'($urandom())} :
                  addr_pool[$urandom_range(0, 3)];
    r.frame_kind = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 3)) :
                   2'($urandom_range(1, 2));
    r.tid = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 2));
    r.byte_size = 16'($urandom());
    return r;
  endfunction

  task automatic run_random(int n, int unsigned step, int enq_pct);
    for (int i = 0; i < n; i++) begin
      tnow += $urandom_range(0, step);
      send_req(rand_req(enq_pct), 1'b0, '0);
    end
  endtask

  initial begin
    rsp_t ok0;
    rsp_t miss0;
    rst_ni   = 1'b0;
    rq.valid <= 1'b0;
    rq.data  <= '0;
    cf.valid <= 1'b0;
    cf.index <= '0;
    cf.wdata <= '0;
    hold_go  <= 1'b0;
    idle_en  = 1'b1;
    shadow_bytes = '0;
    life_ticks   = MAX_DELAY_RST;
    head_drop    = 1'b0;
    cap_reg      = MAX_PACKETS_RST;
    addr_pool[0] = {16'($urandom()), 32'($urandom())};
    addr_pool[1] = {16'($urandom()), 32'($urandom())};
    addr_pool[2] = '1;
    addr_pool[3] = '0;
    ok0 = '0;
    miss0 = '0;
    miss0.status = ST_MISS;

    repeat (11) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed part under reset register values; a stale frame appears once
    // now passes the stamp by more than the default lifetime.
    rows.push_back('{mk_req(REQ_IS_EMPTY, 1000, 0, 0, 0, 0, 0), 1, ok0});
    rows.push_back('{mk_req(REQ_DEQ, 1000, 0, 0, 0, 0, 0), 1, miss0});
    rows.push_back('{mk_req(REQ_TOTALS, 1000, 0, 0, 0, 0, 0), 1, ok0});
    rows.push_back('{mk_req(4'd13, 1000, 0, 0, 0, 0, 0), 1, miss0});
    rows.push_back('{mk_req(4'd15, 1000, '1, '1, '1, '1, '1), 1, miss0});
    rows.push_back('{mk_req(REQ_ENQ, 1000, '1, '1, 2'd3, '1, '1), 1, ok0});
    rows.push_back('{mk_req(REQ_ENQ, 1000, 0, 0, 0, 0, 0), 1, ok0});
    rows.push_back('{mk_req(REQ_ENQ, 1000, 16'h55, addr_pool[0], KIND_QOS, 5, 100), 1, ok0});
    rows.push_back('{mk_req(REQ_PUSH_FRONT, 1000, 16'h66, addr_pool[0], KIND_NQOS, 5, 7),
                     1, ok0});
    rows.push_back('{mk_req(REQ_PEEK, 1000, 0, 0, 0, 0, 0), 0, ok0});
    rows.push_back('{mk_req(REQ_PEEK_TID, 1000, 0, addr_pool[0], 0, 5, 0), 0, ok0});
    rows.push_back('{mk_req(REQ_CNT_ADDR, 1000, 0, addr_pool[0], 0, 0, 0), 0, ok0});
    rows.push_back('{mk_req(REQ_CNT_ADDR, 1000, 0, '1, 0, 0, 0), 0, ok0});
    rows.push_back('{mk_req(REQ_CNT_TID_ADDR, 1000, 0, addr_pool[0], 0, 5, 0), 0, ok0});
    rows.push_back('{mk_req(REQ_TOTALS, 1000, 0, 0, 0, 0, 0), 0, ok0});
    rows.push_back('{mk_req(REQ_DEQ_ADDR, 1000, 0, addr_pool[0], 0, 0, 0), 0, ok0});
    rows.push_back('{mk_req(REQ_DEQ_TID_ADDR, 1000, 0, addr_pool[0], 0, 5, 0), 0, ok0});
    rows.push_back('{mk_req(REQ_REMOVE_ID, 1000, 16'h1234, 0, 0, 0, 0), 1, miss0});
    rows.push_back('{mk_req(REQ_REMOVE_ID, 1000, '1, 0, 0, 0, 0), 1, ok0});
    rows.push_back('{mk_req(REQ_REMOVE_HEAD, 1000, 0, 0, 0, 0, 0), 0, ok0});
    rows.push_back('{mk_req(REQ_DEQ, 1000, 0, 0, 0, 0, 0), 1, miss0});
    rows.push_back('{mk_req(REQ_ENQ, 2000, 16'h77, addr_pool[1], KIND_QOS, 1, 9), 1, ok0});
    rows.push_back('{mk_req(REQ_PEEK, 502001, 0, 0, 0, 0, 0), 1, miss0});
    rows.push_back('{mk_req(REQ_IS_EMPTY, 502001, 0, 0, 0, 0, 0), 1, ok0});
    foreach (rows[i]) send_req(rows[i].r, rows[i].known, rows[i].e);
    drain();

    // Tiny queue, drop-oldest, short lifetime.
    set_regs(32'd40, 1'b1, 7'd4);
    tnow = 32'h2800_0000;
    run_random(80, 10, 35);
    drain();

    // A capacity of zero behaves as one; no lifetime at all.
    set_regs(32'd0, 1'b0, 7'd0);
    tnow = 32'h5000_0000 + $urandom_range(0, 1000);
    run_random(100, 2, 35);
    drain();

    // No idling on either side here.
    idle_en = 1'b0;
    set_regs(32'd300, 1'b0, 7'd64);
    tnow = 32'h7800_0000 + $urandom_range(0, 1000);
    run_random(90, 60, 40);
    drain();
    idle_en = 1'b1;

    // Frames never expire: fill past capacity with enqueues while the
    // response side holds off, then mix.
    set_regs(32'hFFFF_FFFF, 1'b1, 7'd64);
    tnow = 32'hA000_0000 + $urandom_range(0, 1000);
    hold_go <= 1'b1;
    run_random(130, 100, 80);
    drain();
    set_regs(32'hFFFF_FFFF, 1'b0, 7'd64);
    run_random(30, 100, 90);
    drain();

    set_regs(32'd1000, 1'b0, 7'd127);
    tnow = 32'hC800_0000 + $urandom_range(0, 1000);
    run_random(100, 150, 45);
    send_req(mk_req(REQ_ENQ, tnow, 16'h9, addr_pool[1], KIND_QOS, 3, 16'hFFFF), 0, ok0);
    send_req(mk_req(REQ_TOTALS, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 0, ok0);
    drain();
    repeat (150) @(posedge clk_i);

    $display("Sent %0d requests (directed and random over six register settings), %0d responses.",
             n_req, n_rsp);
    $display("Included a 400-cycle response hold-off, full-queue rejects and head drops.");
    if (mism_cnt == 0 && fail_cnt == 0 && rsp_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d field mismatches, %0d unexpected, %0d missing",
               mism_cnt, fail_cnt, rsp_due.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
